>>> src/gcba_pkg.sv
// Shared constants, codes and stage records of the ghost cell address generator.
`timescale 1ns / 1ps

package gcba_pkg;

    localparam int FIELD_W       = 16;
    localparam int CFG_W         = 48;
    localparam int CFG_IDX_W     = 3;
    localparam int INDEX_W       = 32;
    localparam int DEFAULT_MAX_DIM = 1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIMS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_DIMS  = 3'd4;

    // face normal axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // boundary kinds
    localparam logic [2:0] KIND_REFLECT  = 3'd0;
    localparam logic [2:0] KIND_OUTFLOW  = 3'd1;
    localparam logic [2:0] KIND_INFLOW   = 3'd2;
    localparam logic [2:0] KIND_PERIODIC = 3'd3;

    // mover actions
    localparam logic [2:0] ACT_SKIP   = 3'd0;
    localparam logic [2:0] ACT_COPY   = 3'd1;
    localparam logic [2:0] ACT_NEG    = 3'd2;
    localparam logic [2:0] ACT_INFLOW = 3'd3;
    localparam logic [2:0] ACT_ERROR  = 3'd4;

    // after decode: coordinates, strides and table terms
    typedef struct packed {
        logic                           ok;
        logic                           copy;
        logic [2:0]                     act;
        logic [2:0][FIELD_W-1:0]        pos;
        logic [2:0][INDEX_W-1:0]        src;
        logic [FIELD_W-1:0]             g0;
        logic [INDEX_W-1:0]             gxy;
        logic [FIELD_W:0]               ta;
        logic [FIELD_W:0]               tb;
        logic [FIELD_W-1:0]             dt;
    } t_s1;

    // after the multipliers: terms of the three sums
    typedef struct packed {
        logic                           ok;
        logic                           copy;
        logic [2:0]                     act;
        logic [FIELD_W-1:0]             d0;
        logic [INDEX_W-1:0]             dy;
        logic [INDEX_W-1:0]             dz;
        logic [INDEX_W-1:0]             s0;
        logic [INDEX_W-1:0]             sy;
        logic [INDEX_W-1:0]             sz;
        logic [FIELD_W:0]               ta;
        logic [INDEX_W-1:0]             tm;
    } t_s2;

endpackage

>>> src/gcba_decode.sv
// First stage: face existence, ghost and source coordinates, action, plane stride and table terms.
`timescale 1ns / 1ps

module gcba_decode
    import gcba_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [1:0]         i_axis,
    input  logic               i_side,
    input  logic [FIELD_W-1:0] i_layer,
    input  logic [FIELD_W-1:0] i_coord_a,
    input  logic [FIELD_W-1:0] i_coord_b,
    input  logic [2:0]         i_boundary_kind,
    input  logic               i_negate_on_reflect,
    input  logic [CFG_W-1:0]   i_grid,
    input  logic [CFG_W-1:0]   i_start_cfg,
    input  logic [CFG_W-1:0]   i_end_cfg,
    input  logic [CFG_W-1:0]   i_offset,
    input  logic [CFG_W-1:0]   i_domain,
    output logic               o_v,
    output t_s1                o_s
);

    localparam logic [FIELD_W-1:0] MaxDim = FIELD_W'(MAX_DIM);

    logic [2:0][FIELD_W-1:0] g;
    logic [2:0][FIELD_W-1:0] s_cfg;
    logic [2:0][FIELD_W-1:0] e_cfg;
    logic [2:0][FIELD_W-1:0] o_cfg;
    logic [2:0][FIELD_W-1:0] d_cfg;

    logic               r_v;
    t_s1                r_s;
    t_s1                n_s;

    for (genvar k = 0; k < 3; k++) begin : g_unpack
        logic [FIELD_W-1:0] raw;
        assign raw      = i_grid[FIELD_W*k +: FIELD_W];
        assign g[k]     = (raw > MaxDim) ? MaxDim : raw;
        assign s_cfg[k] = i_start_cfg[FIELD_W*k +: FIELD_W];
        assign e_cfg[k] = i_end_cfg[FIELD_W*k +: FIELD_W];
        assign o_cfg[k] = i_offset[FIELD_W*k +: FIELD_W];
        assign d_cfg[k] = i_domain[FIELD_W*k +: FIELD_W];
    end

    always_comb begin
        logic [1:0]         ax;
        logic [1:0]         u;
        logic [1:0]         v;
        logic [FIELD_W-1:0] g_ax;
        logic [FIELD_W-1:0] s_ax;
        logic [FIELD_W-1:0] e_ax;
        logic [FIELD_W-1:0] o_ax;
        logic [FIELD_W-1:0] d_ax;
        logic [FIELD_W:0]   hi_sum;
        logic [FIELD_W+1:0] hi_layer;
        logic               lo_ok;
        logic               hi_ok;
        logic [FIELD_W-1:0] p;
        logic [INDEX_W-1:0] l32;
        logic [INDEX_W-1:0] s32;
        logic [INDEX_W-1:0] e32;
        logic [INDEX_W-1:0] sp;
        ax = (i_axis == AXIS_NONE) ? AXIS_X : i_axis;
        case (ax)
            AXIS_X: begin
                u = AXIS_Y;
                v = AXIS_Z;
            end
            AXIS_Y: begin
                u = AXIS_X;
                v = AXIS_Z;
            end
            default: begin
                u = AXIS_X;
                v = AXIS_Y;
            end
        endcase
        g_ax = g[ax];
        s_ax = s_cfg[ax];
        e_ax = e_cfg[ax];
        o_ax = o_cfg[ax];
        d_ax = d_cfg[ax];

        hi_sum   = {1'b0, o_ax} + {1'b0, g_ax};
        hi_layer = {2'b00, i_layer} + {2'b00, e_ax} + (FIELD_W+2)'(1);
        lo_ok    = (o_ax == '0) && (i_layer < s_ax);
        hi_ok    = (hi_sum == {1'b0, d_ax}) && (hi_layer < {2'b00, g_ax});

        n_s.ok = (i_axis != AXIS_NONE) && (d_ax > FIELD_W'(1))
               && (i_side ? hi_ok : lo_ok)
               && (i_coord_a < g[u]) && (i_coord_b < g[v]);

        p   = i_side ? hi_layer[FIELD_W-1:0] : i_layer;
        l32 = INDEX_W'(i_layer);
        s32 = INDEX_W'(s_ax);
        e32 = INDEX_W'(e_ax);

        // source position along the normal, modulo 2^32
        case (i_boundary_kind)
            KIND_REFLECT: begin
                sp    = i_side ? (e32 - l32) : ((s32 << 1) - INDEX_W'(1) - l32);
                n_s.act = i_negate_on_reflect ? ACT_NEG : ACT_COPY;
            end
            KIND_OUTFLOW: begin
                sp    = i_side ? e32 : s32;
                n_s.act = ACT_COPY;
            end
            KIND_INFLOW: begin
                sp    = '0;
                n_s.act = ACT_INFLOW;
            end
            KIND_PERIODIC: begin
                sp    = i_side ? (s32 + l32) : (l32 + e32 - s32 + INDEX_W'(1));
                n_s.act = ACT_COPY;
            end
            default: begin
                sp    = '0;
                n_s.act = ACT_ERROR;
            end
        endcase
        n_s.copy = (n_s.act == ACT_COPY) || (n_s.act == ACT_NEG);

        for (int k = 0; k < 3; k++) begin
            if (2'(k) == ax) begin
                n_s.pos[k] = p;
                n_s.src[k] = sp;
            end else begin
                n_s.pos[k] = (2'(k) == u) ? i_coord_a : i_coord_b;
                n_s.src[k] = INDEX_W'(n_s.pos[k]);
            end
        end

        n_s.g0  = g[0];
        n_s.gxy = INDEX_W'(g[0]) * INDEX_W'(g[1]);

        if (i_axis == AXIS_X) begin
            n_s.ta = {1'b0, i_coord_a} + {1'b0, o_cfg[1]};
            n_s.tb = {1'b0, i_coord_b} + {1'b0, o_cfg[2]};
            n_s.dt = d_cfg[1];
        end else begin
            n_s.ta = {1'b0, i_coord_a} + {1'b0, o_cfg[0]};
            n_s.tb = {1'b0, i_coord_b} + {1'b0, o_cfg[v]};
            n_s.dt = d_cfg[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_take;
        end
        r_s <= n_s;
    end

    assign o_v = r_v;
    assign o_s = r_s;

endmodule

>>> src/gcba_mult.sv
// Second stage: row, plane and table products, truncated to 32 bits.
`timescale 1ns / 1ps

module gcba_mult
    import gcba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_v,
    input  t_s1  i_s,
    output logic o_v,
    output t_s2  o_s
);

    logic r_v;
    t_s2  r_s;
    t_s2  n_s;

    always_comb begin
        n_s.ok   = i_s.ok;
        n_s.copy = i_s.copy;
        n_s.act  = i_s.act;
        n_s.d0   = i_s.pos[0];
        n_s.dy   = INDEX_W'(i_s.pos[1]) * INDEX_W'(i_s.g0);
        n_s.dz   = INDEX_W'(i_s.pos[2]) * i_s.gxy;
        n_s.s0   = i_s.src[0];
        n_s.sy   = i_s.src[1] * INDEX_W'(i_s.g0);
        n_s.sz   = i_s.src[2] * i_s.gxy;
        n_s.ta   = i_s.ta;
        n_s.tm   = INDEX_W'(i_s.tb) * INDEX_W'(i_s.dt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_v;
        end
        r_s <= n_s;
    end

    assign o_v = r_v;
    assign o_s = r_s;

endmodule

>>> src/gcba_sum.sv
// Third stage: final index sums and the result register.
`timescale 1ns / 1ps

module gcba_sum
    import gcba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_v,
    input  t_s2                i_s,
    output logic               o_valid,
    output logic               o_cell_exists,
    output logic [INDEX_W-1:0] o_dest_index,
    output logic [INDEX_W-1:0] o_source_index,
    output logic [INDEX_W-1:0] o_table_index,
    output logic [2:0]         o_action
);

    logic               r_valid;
    logic               r_exists;
    logic [INDEX_W-1:0] r_dest;
    logic [INDEX_W-1:0] r_source;
    logic [INDEX_W-1:0] r_table;
    logic [2:0]         r_action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_v;
        end
        // drop everything for a cell that does not exist
        r_exists <= i_s.ok;
        r_action <= i_s.ok ? i_s.act : ACT_SKIP;
        r_dest   <= i_s.ok ? (INDEX_W'(i_s.d0) + i_s.dy + i_s.dz) : '0;
        r_source <= (i_s.ok && i_s.copy) ? (i_s.s0 + i_s.sy + i_s.sz) : '0;
        r_table  <= i_s.ok ? (INDEX_W'(i_s.ta) + i_s.tm) : '0;
    end

    assign o_valid        = r_valid;
    assign o_cell_exists  = r_exists;
    assign o_dest_index   = r_dest;
    assign o_source_index = r_source;
    assign o_table_index  = r_table;
    assign o_action       = r_action;

endmodule

>>> src/ghost_cell_boundary_address.sv
// Top level of the ghost cell address generator: configuration registers and stage chain.
`timescale 1ns / 1ps

// Ghost cell address generator for the boundary fill of one 3D grid block.
//
// Configuration: write i_cfg_data to register i_cfg_idx at any edge with
// i_cfg_we high (0 grid dims, 1 active start, 2 active end, 3 block offset,
// 4 domain dims; three 16-bit fields each, x in the low bits). Other
// indexes are ignored. Write only while no transfer is in flight.
//
// Command channel: a cell is taken at an edge where i_start is high and
// o_busy is low. o_busy stays low: the three-stage chain takes one cell
// every cycle, one transfer per clock sustained.
//
// Result channel: o_valid marks each result for exactly one cycle, once its
// command has passed the decode, multiply and sum stages, each with its own
// register. The receiver cannot stall; results leave in command order and
// must be captured on the cycle o_valid is high.
//
// Reset (i_rst_n low, synchronous) clears all configuration to zero and
// empties the chain; nothing in flight survives it.
module ghost_cell_boundary_address
    import gcba_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_axis,
    input  logic                 i_side,
    input  logic [FIELD_W-1:0]   i_layer,
    input  logic [FIELD_W-1:0]   i_coord_a,
    input  logic [FIELD_W-1:0]   i_coord_b,
    input  logic [2:0]           i_boundary_kind,
    input  logic                 i_negate_on_reflect,
    output logic                 o_valid,
    output logic                 o_cell_exists,
    output logic [INDEX_W-1:0]   o_dest_index,
    output logic [INDEX_W-1:0]   o_source_index,
    output logic [INDEX_W-1:0]   o_table_index,
    output logic [2:0]           o_action
);

    logic [CFG_W-1:0] r_grid;
    logic [CFG_W-1:0] r_act_start;
    logic [CFG_W-1:0] r_act_end;
    logic [CFG_W-1:0] r_offset;
    logic [CFG_W-1:0] r_domain;

    logic take;
    logic v1;
    logic v2;
    t_s1  s1;
    t_s2  s2;

    // the chain never stalls, so a command is always taken
    assign o_busy = 1'b0;
    assign take   = i_start && !o_busy;

    // configuration: hold each register until rewritten
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid      <= '0;
            r_act_start <= '0;
            r_act_end   <= '0;
            r_offset    <= '0;
            r_domain    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_DIMS:    r_grid      <= i_cfg_data;
                CFG_ACTIVE_START: r_act_start <= i_cfg_data;
                CFG_ACTIVE_END:   r_act_end   <= i_cfg_data;
                CFG_BLOCK_OFFSET: r_offset    <= i_cfg_data;
                CFG_DOMAIN_DIMS:  r_domain    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage 1: existence check, coordinates, action, plane stride, table terms
    gcba_decode #(
        .MAX_DIM(MAX_DIM)
    ) u_decode (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_take              (take),
        .i_axis              (i_axis),
        .i_side              (i_side),
        .i_layer             (i_layer),
        .i_coord_a           (i_coord_a),
        .i_coord_b           (i_coord_b),
        .i_boundary_kind     (i_boundary_kind),
        .i_negate_on_reflect (i_negate_on_reflect),
        .i_grid              (r_grid),
        .i_start_cfg         (r_act_start),
        .i_end_cfg           (r_act_end),
        .i_offset            (r_offset),
        .i_domain            (r_domain),
        .o_v                 (v1),
        .o_s                 (s1)
    );

    // stage 2: row, plane and table products
    gcba_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (v1),
        .i_s     (s1),
        .o_v     (v2),
        .o_s     (s2)
    );

    // stage 3: index sums and result register
    gcba_sum u_sum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_v            (v2),
        .i_s            (s2),
        .o_valid        (o_valid),
        .o_cell_exists  (o_cell_exists),
        .o_dest_index   (o_dest_index),
        .o_source_index (o_source_index),
        .o_table_index  (o_table_index),
        .o_action       (o_action)
    );

`ifndef SYNTHESIS
    // every taken command yields its result after the decode, multiply and sum registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##3 o_valid)
        else $error("taken command produced no result");

    // a missing cell carries a skip and all indexes cleared
    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_cell_exists) |-> (o_action == ACT_SKIP && o_dest_index == '0
            && o_source_index == '0 && o_table_index == '0))
        else $error("missing cell with nonzero fields");

    // only copies carry a source index
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action != ACT_COPY && o_action != ACT_NEG) |-> o_source_index == '0)
        else $error("source index without a copy");
`endif

endmodule
